// File: src/hfcd_pkg.sv
// Shared types and constants for the humidity frame CRC decoder.
// No dependencies; every other file of the block imports this package.
package hfcd_pkg;

    localparam int HFCD_QUEUE_DEPTH = 4;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TEMP_CRC  = 2'd1,
        STATUS_HUMID_CRC = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] temp_word;
        logic [15:0] humid_word;
    } frame_rec_t;

    typedef struct packed {
        logic       push;
        frame_rec_t rec;
    } rec_write_t;

endpackage

// File: src/hfcd_front.sv
// Front end: tracks byte position, runs the CRC-8 and captures the raw words.
// Hands one frame record per completed frame to the queue. Uses hfcd_pkg.
module hfcd_front
    import hfcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  in_item_t   item,
    output rec_write_t rec_write
);

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    pos_t        pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next, crc_eff;
    logic        tgood_reg, tgood_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] humid_word_reg, humid_word_next;
    status_t     status;

    assign pos_eff = item.frame_start ? POS_T_HI : pos_reg;
    assign crc_eff = item.frame_start ? CRC_INIT : crc_reg;

    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        tgood_next      = tgood_reg;
        temp_word_next  = temp_word_reg;
        humid_word_next = humid_word_reg;
        if (!tgood_reg)
            status = STATUS_TEMP_CRC;
        else if (crc_eff != item.rx_byte)
            status = STATUS_HUMID_CRC;
        else
            status = STATUS_OK;
        if (accept)
        begin
            case (pos_eff)
                POS_T_LO:
                begin
                    temp_word_next = {temp_word_reg[15:8], item.rx_byte};
                    crc_next       = crc8_update(crc_eff, item.rx_byte);
                    pos_next       = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    tgood_next = (crc_eff == item.rx_byte);
                    crc_next   = CRC_INIT;
                    pos_next   = POS_H_HI;
                end
                POS_H_HI:
                begin
                    humid_word_next = {item.rx_byte, humid_word_reg[7:0]};
                    crc_next        = crc8_update(crc_eff, item.rx_byte);
                    pos_next        = POS_H_LO;
                end
                POS_H_LO:
                begin
                    humid_word_next = {humid_word_reg[15:8], item.rx_byte};
                    crc_next        = crc8_update(crc_eff, item.rx_byte);
                    pos_next        = POS_H_CRC;
                end
                POS_H_CRC:
                begin
                    crc_next = CRC_INIT;
                    pos_next = POS_T_HI;
                end
                default:
                begin
                    crc_next       = crc8_update(CRC_INIT, item.rx_byte);
                    temp_word_next = {item.rx_byte, temp_word_reg[7:0]};
                    pos_next       = POS_T_LO;
                end
            endcase
        end
    end

    assign rec_write.push           = accept && (pos_eff == POS_H_CRC);
    assign rec_write.rec.status     = status;
    assign rec_write.rec.temp_word  = temp_word_reg;
    assign rec_write.rec.humid_word = humid_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_T_HI;
            crc_reg   <= CRC_INIT;
            tgood_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            tgood_reg <= tgood_next;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_word_reg  <= temp_word_next;
        humid_word_reg <= humid_word_next;
    end

endmodule

// File: src/hfcd_queue.sv
// Short queue of frame records between the front end and the converter.
// Uses hfcd_pkg for the record type.
module hfcd_queue
    import hfcd_pkg::*;
#(
    parameter int DEPTH = HFCD_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  rec_write_t rec_write,
    output logic       full,
    input  logic       rd_en,
    output frame_rec_t rd_data,
    output logic       empty
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_rec_t       mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (rec_write.push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        case ({rec_write.push, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rec_write.push)
            mem[wr_ptr_reg] <= rec_write.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/hfcd_back.sv
// Back end: scales the raw words in two stages (multiply, then divide by 65535
// with one correction step) and holds the result until it is taken. Uses hfcd_pkg.
module hfcd_back
    import hfcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  frame_rec_t q_data,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result
);

    localparam logic [30:0] T_SCALE  = 31'd17500;
    localparam logic [29:0] H_SCALE  = 30'd10000;
    localparam logic [14:0] T_OFFSET = 15'd4500;
    localparam logic [16:0] DIVISOR  = 17'd65535;

    function automatic logic [14:0] div65535(input logic [30:0] x);
        logic [14:0] q_est;
        logic [16:0] rem;
        q_est = x[30:16];
        rem   = {1'b0, x[15:0]} + {2'b00, q_est};
        return (rem >= DIVISOR) ? q_est + 1'b1 : q_est;
    endfunction

    logic        en;
    logic        s1_valid_reg;
    status_t     s1_status_reg;
    logic [30:0] t_prod_reg;
    logic [29:0] h_prod_reg;
    logic        out_valid_reg;
    out_item_t   out_reg, out_next;
    logic [14:0] t_quot, h_quot;

    assign en    = !out_valid_reg || pop;
    assign q_pop = en && !q_empty;
    assign empty = !out_valid_reg;
    assign result = out_reg;

    assign t_quot = div65535(t_prod_reg);
    assign h_quot = div65535({1'b0, h_prod_reg});

    always_comb
    begin
        out_next.status = s1_status_reg;
        if (s1_status_reg == STATUS_OK)
        begin
            out_next.temperature_centi = t_quot - T_OFFSET;
            out_next.humidity_centi    = h_quot[13:0];
        end
        else
        begin
            out_next.temperature_centi = '0;
            out_next.humidity_centi    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= !q_empty;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_status_reg <= q_data.status;
            t_prod_reg    <= T_SCALE * {15'd0, q_data.temp_word};
            h_prod_reg    <= H_SCALE * {14'd0, q_data.humid_word};
            out_reg       <= out_next;
        end
    end

endmodule

// File: src/humidity_frame_crc_decoder.sv
// Top level of the humidity frame CRC decoder: front end, record queue, converter.
// Depends on hfcd_pkg, hfcd_front, hfcd_queue and hfcd_back.
//
//   channel   | signals                 | request moves
//   ----------+-------------------------+-------------------------------------
//   input     | push, full, item        | one frame byte with its start flag
//   result    | empty, pop, result      | converted temperature, humidity, status
//
// One byte is taken every cycle while full is low; full rises only when the
// record queue holds QUEUE_DEPTH finished frames. The record of a frame is written to
// the queue at the edge that takes its sixth byte; its result then passes the multiply
// stage and the divide stage before it appears.
// rst_n clears position, CRC and all valid state at once; no clearing pass.
// A stalled result holds its converter stage; frames behind it wait in the queue.
module humidity_frame_crc_decoder
    import hfcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = HFCD_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    rec_write_t rec_write;
    frame_rec_t q_data;
    logic       q_empty;
    logic       q_pop;
    logic       accept;

    assign accept = push && !full;

    hfcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .rec_write (rec_write)
    );

    hfcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_write (rec_write),
        .full      (full),
        .rd_en     (q_pop),
        .rd_data   (q_data),
        .empty     (q_empty)
    );

    hfcd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// File: src/hfcd_checker.sv
// Port-level checks for the humidity frame CRC decoder, bound to the top level.
// Depends on hfcd_pkg and humidity_frame_crc_decoder.
module hfcd_checker
    import hfcd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input in_item_t  item,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    a_empty_in_reset: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.status == STATUS_OK || result.status == STATUS_TEMP_CRC ||
                    result.status == STATUS_HUMID_CRC))
        else $error("status code out of range");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != STATUS_OK) |->
            (result.temperature_centi == '0 && result.humidity_centi == '0))
        else $error("failed frame carries nonzero values");

    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STATUS_OK) |->
            (result.humidity_centi <= 14'd10000 &&
             result.temperature_centi >= -15'sd4500 &&
             result.temperature_centi <= 15'sd13000))
        else $error("converted value out of range");

endmodule

bind humidity_frame_crc_decoder hfcd_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
